/* hdl/bsa_pkg.sv */
// Package for the bitmap sector allocator.
// Holds sizes, codes, FSM state type, control structs and bit helpers.
// No dependencies; every other file refers to it by scoped names.
package bsa_pkg;

	localparam int MAX_SECTORS = 4096;
	localparam int WORD_BITS   = 32;
	localparam int WORD_DEPTH  = (MAX_SECTORS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W      = $clog2(WORD_DEPTH);
	localparam int BIT_W       = $clog2(WORD_BITS);

	localparam int SEC_W    = 12;
	localparam int CUR_W    = SEC_W + 1;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	// Highest sector that can ever be valid, clipped to the sector field.
	localparam int LIM_MAX = (MAX_SECTORS - 1 < (1 << SEC_W) - 1) ?
		MAX_SECTORS - 1 : (1 << SEC_W) - 1;

	localparam logic [SEC_W-1:0] LAST_SECTOR_RST = SEC_W'(720);
	localparam logic [CUR_W-1:0] CURSOR_RST      = CUR_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAST_SECTOR = 1'b0,
		CFG_FIRST_FREE  = 1'b1
	} cfg_idx_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_FREE  = 2'd0,
		FN_ALLOC = 2'd1,
		FN_TEST  = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		RS_OK    = 2'd0,
		RS_FULL  = 2'd1,
		RS_RANGE = 2'd2
	} rstat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_EVAL,
		S_DONE
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;   // latch the incoming request
		logic skip;      // request needs no bitmap access: set result now
		logic rd_start;  // read the first word of the request
		logic rd_next;   // advance the allocate scan by one word
		logic finish;    // apply the evaluated word and set result
		logic out_load;  // move result into the output register
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		func_t func;
		logic  skip;      // no bitmap access needed
		logic  hit;       // allocate found a free bit in the current word
		logic  last_word; // scan stands on the word holding the last sector
		logic  out_free;  // output register can take a result
	} sts_t;

	function automatic logic [ADDR_W-1:0] word_idx(input logic [SEC_W-1:0] sec);
		return ADDR_W'(sec >> BIT_W);
	endfunction

	// Lowest set bit of a word; zero when the word is empty.
	function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

/* hdl/bsa_ctrl.sv */
// Controller FSM of the bitmap sector allocator.
// Sequences check, word reads, scan steps and result hand-off.
// Depends on bsa_pkg.
module bsa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bsa_pkg::sts_t   sts,
	output bsa_pkg::cmd_t   cmd
);

	bsa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bsa_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = bsa_pkg::S_CHECK;
				end
			end
			bsa_pkg::S_CHECK: begin
				state_d = sts.skip ? bsa_pkg::S_DONE : bsa_pkg::S_EVAL;
			end
			bsa_pkg::S_EVAL: begin
				if (sts.func != bsa_pkg::FN_ALLOC || sts.hit || sts.last_word) begin
					state_d = bsa_pkg::S_DONE;
				end
			end
			bsa_pkg::S_DONE: begin
				if (sts.out_free) begin
					state_d = bsa_pkg::S_IDLE;
				end
			end
			default: state_d = bsa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			bsa_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			bsa_pkg::S_CHECK: begin
				cmd.skip     = sts.skip;
				cmd.rd_start = !sts.skip;
			end
			bsa_pkg::S_EVAL: begin
				// keep scanning while allocate misses and words remain
				if (sts.func == bsa_pkg::FN_ALLOC && !sts.hit && !sts.last_word) begin
					cmd.rd_next = 1'b1;
				end else begin
					cmd.finish = 1'b1;
				end
			end
			bsa_pkg::S_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* hdl/bsa_dp.sv */
// Datapath of the bitmap sector allocator: bitmap memory with per-row
// valid bits, cursor, limit register, scan logic and output register.
// Depends on bsa_pkg.
module bsa_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bsa_pkg::FUNC_W-1:0]      func,
	input  logic [bsa_pkg::SEC_W-1:0]       sector,
	input  logic                            cfg_we,
	input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsa_pkg::SEC_W-1:0]       cfg_data,
	input  bsa_pkg::cmd_t                   cmd,
	output bsa_pkg::sts_t                   sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bsa_pkg::SEC_W-1:0]       result_sector,
	output logic [bsa_pkg::STATUS_W-1:0]    status,
	output logic                            in_use,
	output logic [bsa_pkg::CUR_W-1:0]       remaining
);

	localparam logic [bsa_pkg::SEC_W-1:0] LimMax = bsa_pkg::SEC_W'(bsa_pkg::LIM_MAX);

	logic [bsa_pkg::WORD_BITS-1:0] mem [bsa_pkg::WORD_DEPTH];
	logic [bsa_pkg::WORD_DEPTH-1:0] row_vld_q;

	bsa_pkg::func_t                 func_q;
	logic [bsa_pkg::SEC_W-1:0]      sector_q;
	logic [bsa_pkg::ADDR_W-1:0]     scan_q;
	logic [bsa_pkg::WORD_BITS-1:0]  rd_data_q;
	logic                           rd_vld_q;
	logic [bsa_pkg::CUR_W-1:0]      cursor_q;
	logic [bsa_pkg::SEC_W-1:0]      last_q;

	logic [bsa_pkg::SEC_W-1:0]      res_sec_q;
	bsa_pkg::rstat_t                res_stat_q;
	logic                           res_used_q;

	logic [bsa_pkg::SEC_W-1:0]      res_sec_out_q;
	logic [bsa_pkg::STATUS_W-1:0]   res_stat_out_q;
	logic                           res_used_out_q;
	logic [bsa_pkg::CUR_W-1:0]      remain_out_q;
	logic                           out_valid_q;

	logic [bsa_pkg::SEC_W-1:0]      lim;
	logic [bsa_pkg::CUR_W-1:0]      lim_ext;
	logic                           cur_past;
	logic [bsa_pkg::SEC_W-1:0]      cur_sec;
	logic [bsa_pkg::ADDR_W-1:0]     cur_word;
	logic [bsa_pkg::ADDR_W-1:0]     lim_word;
	logic [bsa_pkg::BIT_W-1:0]      sec_bit;
	logic                           sec_out;
	logic [bsa_pkg::ADDR_W-1:0]     rd_addr;
	logic                           rd_en;
	logic [bsa_pkg::WORD_BITS-1:0]  word;
	logic [bsa_pkg::WORD_BITS-1:0]  lo_mask;
	logic [bsa_pkg::WORD_BITS-1:0]  hi_mask;
	logic [bsa_pkg::WORD_BITS-1:0]  cand;
	logic [bsa_pkg::BIT_W-1:0]      hit_bit;
	logic [bsa_pkg::SEC_W-1:0]      hit_sec;
	logic [bsa_pkg::WORD_BITS-1:0]  sec_onehot;
	logic                           wr_en;
	logic [bsa_pkg::WORD_BITS-1:0]  wr_data;
	logic [bsa_pkg::CUR_W-1:0]      remain;

	// Valid limit and cursor position.
	always_comb begin
		lim      = (last_q > LimMax) ? LimMax : last_q;
		lim_ext  = {1'b0, lim};
		cur_past = cursor_q > lim_ext;
		cur_sec  = cursor_q[bsa_pkg::SEC_W-1:0];
		cur_word = bsa_pkg::word_idx(cur_sec);
		lim_word = bsa_pkg::word_idx(lim);
		sec_bit  = sector_q[bsa_pkg::BIT_W-1:0];
		sec_out  = sector_q > lim;
		remain   = cur_past ? '0 : lim_ext - cursor_q + bsa_pkg::CUR_W'(1);
	end

	// Word under evaluation; a row never written reads as all used.
	always_comb begin
		word    = rd_vld_q ? rd_data_q : '0;
		lo_mask = (scan_q == cur_word) ?
			({bsa_pkg::WORD_BITS{1'b1}} << cur_sec[bsa_pkg::BIT_W-1:0]) :
			{bsa_pkg::WORD_BITS{1'b1}};
		hi_mask = (scan_q == lim_word) ?
			({bsa_pkg::WORD_BITS{1'b1}} >>
				(bsa_pkg::BIT_W'(bsa_pkg::WORD_BITS - 1) - lim[bsa_pkg::BIT_W-1:0])) :
			{bsa_pkg::WORD_BITS{1'b1}};
		cand       = word & lo_mask & hi_mask;
		hit_bit    = bsa_pkg::first_set(cand);
		hit_sec    = bsa_pkg::SEC_W'({scan_q, hit_bit});
		sec_onehot = bsa_pkg::WORD_BITS'(1) << sec_bit;
	end

	always_comb begin
		rd_en   = cmd.rd_start || cmd.rd_next;
		rd_addr = scan_q + bsa_pkg::ADDR_W'(1);
		if (cmd.rd_start) begin
			rd_addr = (func_q == bsa_pkg::FN_ALLOC) ? cur_word : bsa_pkg::word_idx(sector_q);
		end
		wr_en   = 1'b0;
		wr_data = word | sec_onehot;
		if (cmd.finish) begin
			if (func_q == bsa_pkg::FN_FREE) begin
				wr_en = 1'b1;
			end else if (func_q == bsa_pkg::FN_ALLOC && cand != '0) begin
				wr_en   = 1'b1;
				wr_data = word & ~(bsa_pkg::WORD_BITS'(1) << hit_bit);
			end
		end
	end

	always_comb begin
		sts.func      = func_q;
		sts.skip      = (func_q == bsa_pkg::FN_NOP) ||
			(func_q == bsa_pkg::FN_ALLOC && cur_past) ||
			((func_q == bsa_pkg::FN_FREE || func_q == bsa_pkg::FN_TEST) && sec_out);
		sts.hit       = cand != '0;
		sts.last_word = scan_q == lim_word;
		sts.out_free  = !out_valid_q || out_ready;
	end

	// Bitmap memory: one read and one write port, read data registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_vld_q  <= row_vld_q[rd_addr];
			scan_q    <= rd_addr;
		end
		if (wr_en) begin
			mem[scan_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[scan_q] <= 1'b1;
		end
	end

	// Request capture and result formation.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= bsa_pkg::func_t'(func);
			sector_q <= sector;
		end
		if (cmd.skip) begin
			res_used_q <= 1'b0;
			if (func_q == bsa_pkg::FN_ALLOC) begin
				res_sec_q  <= '0;
				res_stat_q <= bsa_pkg::RS_FULL;
			end else begin
				res_sec_q  <= sector_q;
				res_stat_q <= (func_q == bsa_pkg::FN_NOP) ? bsa_pkg::RS_OK : bsa_pkg::RS_RANGE;
			end
		end
		if (cmd.finish) begin
			res_used_q <= (func_q == bsa_pkg::FN_TEST) && !word[sec_bit];
			if (func_q == bsa_pkg::FN_ALLOC) begin
				res_sec_q  <= (cand != '0) ? hit_sec : '0;
				res_stat_q <= (cand != '0) ? bsa_pkg::RS_OK : bsa_pkg::RS_FULL;
			end else begin
				res_sec_q  <= sector_q;
				res_stat_q <= bsa_pkg::RS_OK;
			end
		end
		if (cmd.out_load) begin
			res_sec_out_q  <= res_sec_q;
			res_stat_out_q <= res_stat_q;
			res_used_out_q <= res_used_q;
			remain_out_q   <= remain;
		end
	end

	// Configuration and cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= bsa_pkg::LAST_SECTOR_RST;
			cursor_q <= bsa_pkg::CURSOR_RST;
		end else begin
			if (cfg_we) begin
				case (bsa_pkg::cfg_idx_t'(cfg_index))
					bsa_pkg::CFG_LAST_SECTOR: last_q   <= cfg_data;
					bsa_pkg::CFG_FIRST_FREE:  cursor_q <= {1'b0, cfg_data};
					default: last_q <= last_q;
				endcase
			end
			// advance cursor past a granted sector
			if (cmd.finish && func_q == bsa_pkg::FN_ALLOC && cand != '0) begin
				cursor_q <= {1'b0, hit_sec} + bsa_pkg::CUR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_sector = res_sec_out_q;
	assign status        = res_stat_out_q;
	assign in_use        = res_used_out_q;
	assign remaining     = remain_out_q;

endmodule

/* hdl/bitmap_sector_allocator.sv */
// Top level of the next-fit bitmap sector allocator.
// Joins the controller FSM (bsa_ctrl) and the datapath (bsa_dp); uses bsa_pkg.
//
//   channel   direction  handshake               payload
//   request   in         in_valid / in_ready     func, sector
//   result    out        out_valid / out_ready   result_sector, status, in_use, remaining
//   config    in         cfg_we                  cfg_index, cfg_data
//
// Free and test requests go through check, word read and evaluate to the result register;
// no-op, out-of-range and allocate with the cursor past the last sector skip the word read.
// Allocate scans bitmap words from the cursor word up to the word of the last sector,
// one word per cycle through the single memory read port, until a free bit is found. Reset
// marks every sector used at once through per-row valid bits, so no clearing
// pass is needed. A result waiting in the output register does not block
// acceptance; a finished request holds only until that register frees.
module bitmap_sector_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bsa_pkg::FUNC_W-1:0]      func,
	input  logic [bsa_pkg::SEC_W-1:0]       sector,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bsa_pkg::SEC_W-1:0]       result_sector,
	output logic [bsa_pkg::STATUS_W-1:0]    status,
	output logic                            in_use,
	output logic [bsa_pkg::CUR_W-1:0]       remaining,
	input  logic                            cfg_we,
	input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsa_pkg::SEC_W-1:0]       cfg_data
);

	bsa_pkg::cmd_t cmd;
	bsa_pkg::sts_t sts;

	bsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func),
		.sector        (sector),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_sector (result_sector),
		.status        (status),
		.in_use        (in_use),
		.remaining     (remaining)
	);

endmodule

/* tb/tb_top.sv */
// Testbench for bitmap_sector_allocator: free, allocate, test and no-op requests
// checked field by field against a next-fit bitmap predictor held in the bench.
// Depends on bsa_pkg and the bitmap_sector_allocator RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bsa_pkg::func_t            op;
		logic [bsa_pkg::SEC_W-1:0] sec;
	} request_t;

	typedef struct {
		logic [bsa_pkg::SEC_W-1:0] sec;
		bsa_pkg::rstat_t           stat;
		logic                      used;
		logic [bsa_pkg::CUR_W-1:0] left;
	} reply_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [bsa_pkg::FUNC_W-1:0]    func = '0;
	logic [bsa_pkg::SEC_W-1:0]     sector = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [bsa_pkg::SEC_W-1:0]     result_sector;
	logic [bsa_pkg::STATUS_W-1:0]  status;
	logic                          in_use;
	logic [bsa_pkg::CUR_W-1:0]     remaining;
	logic                          cfg_we = 1'b0;
	logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bsa_pkg::SEC_W-1:0]     cfg_data = '0;

	request_t pending_q[$];
	reply_t   due_replies[$];
	int       errors = 0;

	// bench copy of the volume: free map, next-fit cursor, last sector register
	logic [bsa_pkg::MAX_SECTORS-1:0] free_map;
	logic [bsa_pkg::CUR_W-1:0]       next_fit;
	logic [bsa_pkg::SEC_W-1:0]       last_reg;

	int send_gap = 0;
	bit send_calm = 1'b0;
	int take_gap = 0;
	bit take_calm = 1'b0;

	bitmap_sector_allocator u_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_wait(inout bit calm);
		// flip now and then between idle-free stretches and random gaps
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic reply_t next_fit_step(request_t req);
		reply_t                    r;
		logic [bsa_pkg::SEC_W-1:0] lim;
		int                        p;
		lim = (last_reg > bsa_pkg::LIM_MAX) ? bsa_pkg::SEC_W'(bsa_pkg::LIM_MAX) : last_reg;
		r.sec = req.sec;
		r.stat = bsa_pkg::RS_OK;
		r.used = 1'b0;
		case (req.op)
			bsa_pkg::FN_FREE: begin
				if (req.sec > lim)
					r.stat = bsa_pkg::RS_RANGE;
				else
					free_map[req.sec] = 1'b1;
			end
			bsa_pkg::FN_ALLOC: begin
				p = next_fit;
				while (p <= lim && !free_map[p])
					p++;
				if (p <= lim) begin
					free_map[p] = 1'b0;
					next_fit = bsa_pkg::CUR_W'(p + 1);
					r.sec = bsa_pkg::SEC_W'(p);
				end else begin
					r.stat = bsa_pkg::RS_FULL;
					r.sec = '0;
				end
			end
			bsa_pkg::FN_TEST: begin
				if (req.sec > lim)
					r.stat = bsa_pkg::RS_RANGE;
				else
					r.used = !free_map[req.sec];
			end
			default: ;
		endcase
		r.left = (next_fit > lim) ? '0 :
			bsa_pkg::CUR_W'(int'(lim) - int'(next_fit) + 1);
		return r;
	endfunction

	// driver: owns the predictor, which advances on every accepted request
	always @(posedge clk or negedge arst_n) begin
		request_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
			free_map = '0;
			next_fit = bsa_pkg::CURSOR_RST;
			last_reg = bsa_pkg::LAST_SECTOR_RST;
			send_gap = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == bsa_pkg::CFG_LAST_SECTOR)
					last_reg = cfg_data;
				else
					next_fit = bsa_pkg::CUR_W'(cfg_data);
			end
			if (in_valid && in_ready)
				due_replies.push_back(next_fit_step('{bsa_pkg::func_t'(func), sector}));
			// hold the payload until the request is taken
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					req = pending_q.pop_front();
					func <= req.op;
					sector <= req.sec;
					in_valid <= 1'b1;
					send_gap = pick_wait(send_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result with the oldest predicted reply
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			take_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_replies.size() == 0) begin
					$error("result with no request outstanding: result_sector %0d", result_sector);
					errors++;
				end else begin
					want = due_replies.pop_front();
					if (result_sector !== want.sec) begin
						$error("result_sector: expected %0d, got %0d", want.sec, result_sector);
						errors++;
					end
					if (status !== want.stat) begin
						$error("status: expected %0d, got %0d", want.stat, status);
						errors++;
					end
					if (in_use !== want.used) begin
						$error("in_use: expected %0d, got %0d", want.used, in_use);
						errors++;
					end
					if (remaining !== want.left) begin
						$error("remaining: expected %0d, got %0d", want.left, remaining);
						errors++;
					end
				end
				take_gap = pick_wait(take_calm);
				out_ready <= (take_gap == 0);
			end else if (take_gap > 0) begin
				take_gap--;
				out_ready <= (take_gap == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push(bsa_pkg::func_t op, int s);
		pending_q.push_back('{op, bsa_pkg::SEC_W'(s)});
	endtask

	// wait until every request is sent and answered, then let the block drain
	task automatic settle();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || in_valid || due_replies.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_volume(int last, int first);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= bsa_pkg::CFG_LAST_SECTOR;
		cfg_data <= bsa_pkg::SEC_W'(last);
		@(posedge clk);
		cfg_index <= bsa_pkg::CFG_FIRST_FREE;
		cfg_data <= bsa_pkg::SEC_W'(first);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int last;
		int first;
		int lo;
		int hi;
		int n;
		int k;
		int r;
		bsa_pkg::func_t op;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset volume: last sector 720, cursor 4, every sector used
		push(bsa_pkg::FN_TEST, 0);
		push(bsa_pkg::FN_FREE, 0);
		push(bsa_pkg::FN_TEST, 0);
		push(bsa_pkg::FN_FREE, 720);
		push(bsa_pkg::FN_FREE, 721);
		push(bsa_pkg::FN_TEST, 4095);
		push(bsa_pkg::FN_FREE, 5);
		push(bsa_pkg::FN_ALLOC, 0);
		push(bsa_pkg::FN_ALLOC, 4095);
		push(bsa_pkg::FN_ALLOC, 0);
		push(bsa_pkg::FN_FREE, 4);
		push(bsa_pkg::FN_ALLOC, 0);
		push(bsa_pkg::FN_NOP, 4095);
		push(bsa_pkg::FN_TEST, 720);
		settle();

		// top of the sector range: cursor runs off the end
		set_volume(4095, 4095);
		push(bsa_pkg::FN_FREE, 4095);
		push(bsa_pkg::FN_ALLOC, 0);
		push(bsa_pkg::FN_ALLOC, 0);
		push(bsa_pkg::FN_TEST, 2048);
		settle();

		// smallest volume
		set_volume(1, 1);
		push(bsa_pkg::FN_FREE, 1);
		push(bsa_pkg::FN_TEST, 1);
		push(bsa_pkg::FN_ALLOC, 0);
		push(bsa_pkg::FN_FREE, 2);
		push(bsa_pkg::FN_ALLOC, 0);
		settle();

		// cursor already beyond the last sector
		set_volume(100, 3000);
		push(bsa_pkg::FN_FREE, 50);
		push(bsa_pkg::FN_ALLOC, 0);
		settle();

		for (int ph = 0; ph < 9; ph++) begin
			case ($urandom_range(0, 3))
				0: last = 4095;
				1: last = $urandom_range(16, 300);
				2: last = $urandom_range(1, 4095);
				default: last = $urandom_range(300, 1200);
			endcase
			first = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4095) :
				$urandom_range(1, last);
			set_volume(last, first);
			lo = (first > 8) ? first - 8 : 0;
			hi = (last + 8 > 4095) ? 4095 : last + 8;
			n = 0;
			while (n < 75) begin
				if ($urandom_range(0, 9) < 3) begin
					// release a handful of sectors, then claim as many
					k = $urandom_range(1, 6);
					repeat (k) push(bsa_pkg::FN_FREE, $urandom_range(first, last));
					repeat (k) push(bsa_pkg::FN_ALLOC, $urandom);
					n += 2 * k;
				end else begin
					r = $urandom_range(0, 99);
					op = (r < 40) ? bsa_pkg::FN_FREE : (r < 70) ? bsa_pkg::FN_ALLOC :
						(r < 92) ? bsa_pkg::FN_TEST : bsa_pkg::FN_NOP;
					push(op, ($urandom_range(0, 6) == 0) ? $urandom_range(0, 4095) :
						$urandom_range(lo, hi));
					n++;
				end
			end
			settle();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
hdl/bsa_pkg.sv
hdl/bsa_ctrl.sv
hdl/bsa_dp.sv
hdl/bitmap_sector_allocator.sv
tb/tb_top.sv
